>>> hw/rtl/rcbe_pkg.sv
// ----------------------------------------------------------------------------
// RNS centered base extension: shared package
// Widths, register indexes and types used by the block and its interfaces.
// ----------------------------------------------------------------------------
package rcbe_pkg;

    localparam int RES_W     = 60;
    localparam int WIDE_W    = 2 * RES_W;
    localparam int HALF_W    = RES_W / 2;
    localparam int TOP_MAX   = 4;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_LOW_A = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LOW_B = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_INV   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_TOP_0 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_TOP_1 = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_TOP_2 = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_TOP_3 = 3'd6;

    typedef logic [RES_W-1:0]  res_t;
    typedef logic [WIDE_W-1:0] wide_t;

endpackage

>>> hw/rtl/rcbe_in_if.sv
// ----------------------------------------------------------------------------
// RNS centered base extension: input channel
// One word is one coefficient given as two low-level residues.
// ----------------------------------------------------------------------------
interface rcbe_in_if import rcbe_pkg::*; ();

    logic valid;
    logic ready;
    res_t residue_a;
    res_t residue_b;

    modport source (output valid, output residue_a, output residue_b, input ready);
    modport sink (input valid, input residue_a, input residue_b, output ready);

endinterface

>>> hw/rtl/rcbe_out_if.sv
// ----------------------------------------------------------------------------
// RNS centered base extension: output channel
// One word is the coefficient reduced modulo each of four top-level moduli.
// ----------------------------------------------------------------------------
interface rcbe_out_if import rcbe_pkg::*; ();

    logic valid;
    logic ready;
    res_t out_residue_0;
    res_t out_residue_1;
    res_t out_residue_2;
    res_t out_residue_3;

    modport source (
        output valid, output out_residue_0, output out_residue_1,
        output out_residue_2, output out_residue_3, input ready
    );
    modport sink (
        input valid, input out_residue_0, input out_residue_1,
        input out_residue_2, input out_residue_3, output ready
    );

endinterface

>>> hw/rtl/rcbe_mod_pipe.sv
// ----------------------------------------------------------------------------
// RNS centered base extension: pipelined modular reduction
// Restoring reduction of an IN_W-bit value, one bit per stage, in parallel lanes.
// ----------------------------------------------------------------------------
module rcbe_mod_pipe import rcbe_pkg::*; #(
    parameter int LANES  = 1,
    parameter int IN_W   = 60,
    parameter int SIDE_W = 1
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic [LANES-1:0][IN_W-1:0]       in_value,
    input  logic [LANES-1:0][RES_W-1:0]      modulus,
    input  logic [SIDE_W-1:0]                in_side,
    output logic                             out_valid,
    output logic [LANES-1:0][RES_W-1:0]      out_rem,
    output logic [SIDE_W-1:0]                out_side
);

    logic [IN_W-1:0]                  vld_reg;
    logic [LANES-1:0][RES_W-1:0]      rem_reg  [IN_W];
    logic [LANES-1:0][IN_W-1:0]       val_reg  [IN_W];
    logic [SIDE_W-1:0]                side_reg [IN_W];

    for (genvar k = 0; k < IN_W; k++)
    begin : g_stage
        logic                        vld_prev;
        logic [LANES-1:0][RES_W-1:0] rem_prev;
        logic [LANES-1:0][IN_W-1:0]  val_prev;
        logic [SIDE_W-1:0]           side_prev;
        logic [LANES-1:0][RES_W-1:0] rem_next;
        logic [LANES-1:0][IN_W-1:0]  val_next;

        if (k == 0)
        begin : g_first
            assign vld_prev  = in_valid;
            assign rem_prev  = '0;
            assign val_prev  = in_value;
            assign side_prev = in_side;
        end
        else
        begin : g_next
            assign vld_prev  = vld_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign val_prev  = val_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        always_comb
        begin
            logic [RES_W:0] trial;
            for (int l = 0; l < LANES; l++)
            begin
                trial = {rem_prev[l], val_prev[l][IN_W-1]};
                if (trial >= {1'b0, modulus[l]})
                begin
                    trial = trial - {1'b0, modulus[l]};
                end
                rem_next[l] = trial[RES_W-1:0];
                val_next[l] = {val_prev[l][IN_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                val_reg[k]  <= val_next;
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_valid = vld_reg[IN_W-1];
    assign out_rem   = rem_reg[IN_W-1];
    assign out_side  = side_reg[IN_W-1];

endmodule

>>> hw/rtl/rcbe_mulmod.sv
// ----------------------------------------------------------------------------
// RNS centered base extension: pipelined modular multiplier
// Double-and-add product modulo a modulus, one multiplier bit per stage.
// ----------------------------------------------------------------------------
module rcbe_mulmod import rcbe_pkg::*; #(
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  res_t              in_x,
    input  res_t              in_y,
    input  res_t              modulus,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output res_t              out_prod,
    output logic [SIDE_W-1:0] out_side
);

    logic [RES_W-1:0]  vld_reg;
    res_t              acc_reg  [RES_W];
    res_t              x_reg    [RES_W];
    res_t              y_reg    [RES_W];
    logic [SIDE_W-1:0] side_reg [RES_W];

    for (genvar k = 0; k < RES_W; k++)
    begin : g_stage
        logic              vld_prev;
        res_t              acc_prev;
        res_t              x_prev;
        res_t              y_prev;
        logic [SIDE_W-1:0] side_prev;
        res_t              acc_next;

        if (k == 0)
        begin : g_first
            assign vld_prev  = in_valid;
            assign acc_prev  = '0;
            assign x_prev    = in_x;
            assign y_prev    = in_y;
            assign side_prev = in_side;
        end
        else
        begin : g_next
            assign vld_prev  = vld_reg[k-1];
            assign acc_prev  = acc_reg[k-1];
            assign x_prev    = x_reg[k-1];
            assign y_prev    = y_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        always_comb
        begin
            logic [RES_W:0] dbl;
            logic [RES_W:0] sum;
            dbl = {acc_prev, 1'b0};
            if (dbl >= {1'b0, modulus})
            begin
                dbl = dbl - {1'b0, modulus};
            end
            sum = {1'b0, dbl[RES_W-1:0]} + (y_prev[RES_W-1] ? {1'b0, x_prev} : '0);
            if (sum >= {1'b0, modulus})
            begin
                sum = sum - {1'b0, modulus};
            end
            acc_next = sum[RES_W-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                acc_reg[k]  <= acc_next;
                x_reg[k]    <= x_prev;
                y_reg[k]    <= {y_prev[RES_W-2:0], 1'b0};
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_valid = vld_reg[RES_W-1];
    assign out_prod  = acc_reg[RES_W-1];
    assign out_side  = side_reg[RES_W-1];

endmodule

>>> hw/rtl/rns_centered_base_extension_top.sv
// ----------------------------------------------------------------------------
// RNS centered base extension: top level
// Rebuilds a coefficient from two residues and re-reduces its centered value.
// ----------------------------------------------------------------------------
// The coeff channel takes one word per cycle while coeff.ready is high: the
// residues of a coefficient modulo the two low moduli. The result channel
// returns one word per input word, in order: the coefficient, centered into
// (-M/2, M/2], reduced modulo each top modulus. Outputs beyond TOP_MODULI
// read as zero. The user must write the moduli and the inverse through the
// cfg_wr port only while the block is idle; the block does not enforce this.
// The datapath is a fully pipelined chain: low residue reduction, a second
// reduction modulo the second modulus, a difference register, a bit-serial
// modular multiply, two multiply stages, two centering stages, a final
// 120-stage reduction and a sign fix-up register. One word is accepted per
// cycle while coeff.ready is high. When the receiver stalls, the output
// register and one skid entry absorb the last words; the whole pipeline
// then holds and coeff.ready drops until the skid entry drains. Reset
// empties the pipeline and loads the register defaults.
// ----------------------------------------------------------------------------
module rns_centered_base_extension_top import rcbe_pkg::*; #(
    parameter int TOP_MODULI = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    rcbe_in_if.sink              coeff,
    rcbe_out_if.source           result,
    input  logic                 cfg_wr_en,
    input  logic [REG_IDX_W-1:0] cfg_wr_index,
    input  res_t                 cfg_wr_data
);

    res_t low_a_reg;
    res_t low_b_reg;
    res_t inv_reg;
    res_t top_mod_reg [TOP_MAX];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_a_reg <= RES_W'(2);
            low_b_reg <= RES_W'(2);
            inv_reg   <= '0;
            for (int m = 0; m < TOP_MAX; m++)
            begin
                top_mod_reg[m] <= RES_W'(2);
            end
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_wr_index)
                REG_LOW_A: low_a_reg      <= cfg_wr_data;
                REG_LOW_B: low_b_reg      <= cfg_wr_data;
                REG_INV:   inv_reg        <= cfg_wr_data;
                REG_TOP_0: top_mod_reg[0] <= cfg_wr_data;
                REG_TOP_1: top_mod_reg[1] <= cfg_wr_data;
                REG_TOP_2: top_mod_reg[2] <= cfg_wr_data;
                REG_TOP_3: top_mod_reg[3] <= cfg_wr_data;
                default:   ;
            endcase
        end
    end

    logic en;
    logic skid_valid_reg;
    logic out_valid_reg;

    assign en          = !skid_valid_reg;
    assign coeff.ready = en;

    // Low residue reduction: residue_a mod A, residue_b mod B, inverse mod B.
    logic                        zero_low;
    logic                        p1_valid;
    logic [2:0][RES_W-1:0]       p1_rem;
    logic                        p1_zero;

    assign zero_low = (low_a_reg == '0) || (low_b_reg == '0);

    rcbe_mod_pipe #(.LANES(3), .IN_W(RES_W), .SIDE_W(1)) u_low_red (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (coeff.valid),
        .in_value  ({inv_reg, coeff.residue_b, coeff.residue_a}),
        .modulus   ({low_b_reg, low_b_reg, low_a_reg}),
        .in_side   (zero_low),
        .out_valid (p1_valid),
        .out_rem   (p1_rem),
        .out_side  (p1_zero)
    );

    // Reduction of the first residue modulo B.
    localparam int P2_SIDE_W = 1 + 3 * RES_W;
    logic                        p2_valid;
    logic [0:0][RES_W-1:0]       p2_rem;
    logic [P2_SIDE_W-1:0]        p2_side;

    rcbe_mod_pipe #(.LANES(1), .IN_W(RES_W), .SIDE_W(P2_SIDE_W)) u_cross_red (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p1_valid),
        .in_value  (p1_rem[0]),
        .modulus   (low_b_reg),
        .in_side   ({p1_zero, p1_rem[2], p1_rem[1], p1_rem[0]}),
        .out_valid (p2_valid),
        .out_rem   (p2_rem),
        .out_side  (p2_side)
    );

    // Garner difference (rb - ra) mod B.
    logic           d_valid_reg;
    res_t           d_diff_reg;
    res_t           d_inv_reg;
    res_t           d_ra_reg;
    logic           d_zero_reg;
    logic [RES_W:0] d_diff_next;
    res_t           p2_ra;
    res_t           p2_rb;

    assign p2_ra = p2_side[RES_W-1:0];
    assign p2_rb = p2_side[2*RES_W-1:RES_W];

    always_comb
    begin
        if (p2_rb >= p2_rem[0])
        begin
            d_diff_next = {1'b0, p2_rb} - {1'b0, p2_rem[0]};
        end
        else
        begin
            d_diff_next = {1'b0, p2_rb} + {1'b0, low_b_reg} - {1'b0, p2_rem[0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            d_valid_reg <= p2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_diff_reg <= d_diff_next[RES_W-1:0];
            d_inv_reg  <= p2_side[3*RES_W-1:2*RES_W];
            d_ra_reg   <= p2_ra;
            d_zero_reg <= p2_side[P2_SIDE_W-1];
        end
    end

    // t = diff * inverse mod B.
    logic             p3_valid;
    res_t             p3_t;
    logic [RES_W:0]   p3_side;

    rcbe_mulmod #(.SIDE_W(RES_W + 1)) u_garner_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d_valid_reg),
        .in_x      (d_diff_reg),
        .in_y      (d_inv_reg),
        .modulus   (low_b_reg),
        .in_side   ({d_zero_reg, d_ra_reg}),
        .out_valid (p3_valid),
        .out_prod  (p3_t),
        .out_side  (p3_side)
    );

    // Partial products of A*t and A*B.
    logic                  m1_valid_reg;
    logic [3:0][RES_W-1:0] m1_pt_reg;
    logic [3:0][RES_W-1:0] m1_pm_reg;
    res_t                  m1_ra_reg;
    logic                  m1_zero_reg;
    logic [HALF_W-1:0]     a_lo;
    logic [HALF_W-1:0]     a_hi;
    logic [HALF_W-1:0]     b_lo;
    logic [HALF_W-1:0]     b_hi;
    logic [HALF_W-1:0]     t_lo;
    logic [HALF_W-1:0]     t_hi;
    logic [3:0][RES_W-1:0] m1_pt_next;
    logic [3:0][RES_W-1:0] m1_pm_next;

    assign a_lo = low_a_reg[HALF_W-1:0];
    assign a_hi = low_a_reg[RES_W-1:HALF_W];
    assign b_lo = low_b_reg[HALF_W-1:0];
    assign b_hi = low_b_reg[RES_W-1:HALF_W];
    assign t_lo = p3_t[HALF_W-1:0];
    assign t_hi = p3_t[RES_W-1:HALF_W];

    always_comb
    begin
        m1_pt_next[0] = a_lo * t_lo;
        m1_pt_next[1] = a_lo * t_hi;
        m1_pt_next[2] = a_hi * t_lo;
        m1_pt_next[3] = a_hi * t_hi;
        m1_pm_next[0] = a_lo * b_lo;
        m1_pm_next[1] = a_lo * b_hi;
        m1_pm_next[2] = a_hi * b_lo;
        m1_pm_next[3] = a_hi * b_hi;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m1_valid_reg <= p3_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_pt_reg   <= m1_pt_next;
            m1_pm_reg   <= m1_pm_next;
            m1_ra_reg   <= p3_side[RES_W-1:0];
            m1_zero_reg <= p3_side[RES_W];
        end
    end

    // X = A*t + ra and M = A*B.
    logic  m2_valid_reg;
    wide_t m2_x_reg;
    wide_t m2_m_reg;
    logic  m2_zero_reg;
    wide_t m2_x_next;
    wide_t m2_m_next;

    always_comb
    begin
        m2_x_next = (WIDE_W'(m1_pt_reg[3]) << (2 * HALF_W))
                  + ((WIDE_W'(m1_pt_reg[1]) + WIDE_W'(m1_pt_reg[2])) << HALF_W)
                  + WIDE_W'(m1_pt_reg[0]) + WIDE_W'(m1_ra_reg);
        m2_m_next = (WIDE_W'(m1_pm_reg[3]) << (2 * HALF_W))
                  + ((WIDE_W'(m1_pm_reg[1]) + WIDE_W'(m1_pm_reg[2])) << HALF_W)
                  + WIDE_W'(m1_pm_reg[0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m2_valid_reg <= m1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m2_x_reg    <= m2_x_next;
            m2_m_reg    <= m2_m_next;
            m2_zero_reg <= m1_zero_reg;
        end
    end

    // Centering: compare with M/2, then take the magnitude.
    logic  c1_valid_reg;
    wide_t c1_x_reg;
    wide_t c1_m_reg;
    logic  c1_neg_reg;
    logic  c1_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            c1_valid_reg <= m2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_x_reg    <= m2_x_reg;
            c1_m_reg    <= m2_m_reg;
            c1_neg_reg  <= m2_x_reg > (m2_m_reg >> 1);
            c1_zero_reg <= m2_zero_reg;
        end
    end

    logic  c2_valid_reg;
    wide_t c2_mag_reg;
    logic  c2_neg_reg;
    logic  c2_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            c2_valid_reg <= c1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c2_mag_reg  <= c1_neg_reg ? (c1_m_reg - c1_x_reg) : c1_x_reg;
            c2_neg_reg  <= c1_neg_reg;
            c2_zero_reg <= c1_zero_reg;
        end
    end

    // Reduction of the magnitude modulo each top modulus.
    logic [TOP_MODULI-1:0][WIDE_W-1:0] p4_value;
    logic [TOP_MODULI-1:0][RES_W-1:0]  p4_mod;
    logic                              p4_valid;
    logic [TOP_MODULI-1:0][RES_W-1:0]  p4_rem;
    logic [1:0]                        p4_side;

    for (genvar m = 0; m < TOP_MODULI; m++)
    begin : g_top_in
        assign p4_value[m] = c2_mag_reg;
        assign p4_mod[m]   = top_mod_reg[m];
    end

    rcbe_mod_pipe #(.LANES(TOP_MODULI), .IN_W(WIDE_W), .SIDE_W(2)) u_top_red (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c2_valid_reg),
        .in_value  (p4_value),
        .modulus   (p4_mod),
        .in_side   ({c2_zero_reg, c2_neg_reg}),
        .out_valid (p4_valid),
        .out_rem   (p4_rem),
        .out_side  (p4_side)
    );

    // Sign fix-up and forcing of the zero cases.
    logic f_valid_reg;
    res_t f_res_reg  [TOP_MAX];
    res_t f_res_next [TOP_MAX];

    for (genvar m = 0; m < TOP_MAX; m++)
    begin : g_fix
        if (m < TOP_MODULI)
        begin : g_used
            always_comb
            begin
                if (p4_side[1] || (top_mod_reg[m] == '0))
                begin
                    f_res_next[m] = '0;
                end
                else if (p4_side[0] && (p4_rem[m] != '0))
                begin
                    f_res_next[m] = top_mod_reg[m] - p4_rem[m];
                end
                else
                begin
                    f_res_next[m] = p4_rem[m];
                end
            end
        end
        else
        begin : g_unused
            assign f_res_next[m] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            f_valid_reg <= p4_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_res_reg <= f_res_next;
        end
    end

    // Output register with one skid entry.
    res_t out_reg  [TOP_MAX];
    res_t skid_reg [TOP_MAX];
    logic take;
    logic fire;

    assign take = en && f_valid_reg;
    assign fire = out_valid_reg && result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (skid_valid_reg)
            begin
                if (fire)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (out_valid_reg)
            begin
                if (fire)
                begin
                    out_valid_reg <= take;
                end
                else if (take)
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else
            begin
                out_valid_reg <= take;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (skid_valid_reg)
        begin
            if (fire)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (!out_valid_reg || fire)
        begin
            if (take)
            begin
                out_reg <= f_res_reg;
            end
        end
        else
        begin
            if (take)
            begin
                skid_reg <= f_res_reg;
            end
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.out_residue_0 = out_reg[0];
    assign result.out_residue_1 = out_reg[1];
    assign result.out_residue_2 = out_reg[2];
    assign result.out_residue_3 = out_reg[3];

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a word while the output register is empty");

    a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !result.ready))
        else $error("skid entry filled without a stalled output");

    a_pipe_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (f_valid_reg && !en) |=> (f_valid_reg && $stable(f_res_reg[0])))
        else $error("last pipeline stage changed during a stall");

endmodule

>>> sim/tb_rcbe_channels.sv
// ----------------------------------------------------------------------------
// RNS centered base extension: testbench channel instances
// Interfaces used by the testbench are those of the RTL; this file holds
// a small bundle that groups the configuration write port signals.
// ----------------------------------------------------------------------------
interface tb_rcbe_cfg_if import rcbe_pkg::*; ();

    logic                 wr_en;
    logic [REG_IDX_W-1:0] wr_index;
    res_t                 wr_data;

    modport source (output wr_en, output wr_index, output wr_data);
    modport sink (input wr_en, input wr_index, input wr_data);

endinterface

>>> sim/tb_rns_centered_base_extension_top.sv
// ----------------------------------------------------------------------------
// RNS centered base extension: self-checking testbench
// Drives coefficient words with bursty timing while the result side stalls,
// rebuilds each coefficient with an in-bench CRT predictor across several
// modulus settings, and compares every result word with the predicted word.
// ----------------------------------------------------------------------------
module tb_rns_centered_base_extension_top;
    import rcbe_pkg::*;

    localparam int PIPE_LAT = 306;
    localparam logic [RES_W-1:0] MAXV = {RES_W{1'b1}};
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        res_t r0;
        res_t r1;
        res_t r2;
        res_t r3;
    } extended_t;

    typedef struct {
        res_t ra;
        res_t rb;
        bit   known;
        res_t k0;
    } coeff_row_t;

    logic clk;
    logic rst_n;

    rcbe_in_if     coeff();
    rcbe_out_if    result();
    tb_rcbe_cfg_if cfg();

    rns_centered_base_extension_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .coeff        (coeff),
        .result       (result),
        .cfg_wr_en    (cfg.wr_en),
        .cfg_wr_index (cfg.wr_index),
        .cfg_wr_data  (cfg.wr_data)
    );

    res_t      mod_a;
    res_t      mod_b;
    res_t      inv_ab;
    res_t      top_mod [TOP_MAX];
    extended_t pending_words[$];
    int        mismatches;
    bit        stall_mode;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2000000000;
        $display("status: fail");
        $finish;
    end

    function automatic extended_t extend_coeff(res_t ra_in, res_t rb_in);
        extended_t ext;
        logic [WIDE_W:0] x;
        logic [WIDE_W:0] m;
        logic [WIDE_W:0] mag;
        logic [WIDE_W:0] rem_v;
        logic [WIDE_W:0] ra;
        logic [WIDE_W:0] rb;
        logic [WIDE_W:0] t;
        logic [WIDE_W:0] inv;
        bit neg;
        res_t outs [TOP_MAX];
        ext = '0;
        if (mod_a == 0 || mod_b == 0)
        begin
            return ext;
        end
        ra = ra_in % mod_a;
        rb = rb_in % mod_b;
        inv = inv_ab % mod_b;
        t = ((rb + mod_b - (ra % mod_b)) % mod_b) * inv % mod_b;
        x = mod_a * t + ra;
        m = mod_a * mod_b;
        neg = x > (m >> 1);
        mag = neg ? m - x : x;
        for (int i = 0; i < TOP_MAX; i++)
        begin
            outs[i] = '0;
            if (top_mod[i] != 0)
            begin
                rem_v = mag % top_mod[i];
                if (neg && rem_v != 0)
                begin
                    rem_v = top_mod[i] - rem_v;
                end
                outs[i] = rem_v[RES_W-1:0];
            end
        end
        ext.r0 = outs[0];
        ext.r1 = outs[1];
        ext.r2 = outs[2];
        ext.r3 = outs[3];
        return ext;
    endfunction

    function automatic res_t rand_res();
        return res_t'({$urandom(), $urandom()});
    endfunction

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, res_t value);
        cfg.wr_en    <= 1'b1;
        cfg.wr_index <= idx;
        cfg.wr_data  <= value;
        @(posedge clk);
        cfg.wr_en    <= 1'b0;
        if (idx == REG_LOW_A) mod_a = value;
        else if (idx == REG_LOW_B) mod_b = value;
        else if (idx == REG_INV) inv_ab = value;
        else if (idx <= REG_TOP_3) top_mod[idx - REG_TOP_0] = value;
        @(posedge clk);
    endtask

    task automatic drain();
        while (pending_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (PIPE_LAT + 20) @(posedge clk);
    endtask

    task automatic send_coeff(res_t ra, res_t rb);
        coeff.valid     <= 1'b1;
        coeff.residue_a <= ra;
        coeff.residue_b <= rb;
        @(posedge clk);
        while (!coeff.ready)
        begin
            @(posedge clk);
        end
        pending_words.push_back(extend_coeff(ra, rb));
    endtask

    task automatic send_random(int count, bit unreduced);
        int left;
        int burst;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && left > 0)
            begin
                if (unreduced || $urandom_range(0, 9) == 0 || mod_a == 0 || mod_b == 0)
                begin
                    send_coeff(rand_res(), rand_res());
                end
                else
                begin
                    send_coeff(rand_res() % mod_a, rand_res() % mod_b);
                end
                burst--;
                left--;
            end
            if ($urandom_range(0, 3) != 0)
            begin
                coeff.valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
        coeff.valid <= 1'b0;
    endtask

    // Stall pattern of the receiver: alternate runs of free flow and random stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result.ready <= 1'b0;
            stall_mode   <= 1'b0;
        end
        else
        begin
            if ($urandom_range(0, 63) == 0)
            begin
                stall_mode <= ~stall_mode;
            end
            result.ready <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b1;
        end
    end

    always @(posedge clk)
    begin
        extended_t want;
        extended_t got;
        if (rst_n && result.valid && result.ready)
        begin
            got.r0 = result.out_residue_0;
            got.r1 = result.out_residue_1;
            got.r2 = result.out_residue_2;
            got.r3 = result.out_residue_3;
            if (pending_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result word %h", got);
                end
            end
            else
            begin
                want = pending_words.pop_front();
                if (want != got)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: expected %h %h %h %h got %h %h %h %h",
                                 want.r0, want.r1, want.r2, want.r3,
                                 got.r0, got.r1, got.r2, got.r3);
                    end
                end
            end
        end
    end

    initial
    begin
        coeff_row_t rows[$];
        extended_t  want;
        res_t       p;
        mismatches      = 0;
        mod_a           = 2;
        mod_b           = 2;
        inv_ab          = 0;
        for (int i = 0; i < TOP_MAX; i++) top_mod[i] = 2;
        rst_n           = 1'b0;
        coeff.valid     = 1'b0;
        coeff.residue_a = '0;
        coeff.residue_b = '0;
        cfg.wr_en       = 1'b0;
        cfg.wr_index    = '0;
        cfg.wr_data     = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: A = B = 2, inverse 0, so X = ra mod 2 and M = 4.
        rows = '{
            '{res_t'(0), res_t'(0), 1'b1, res_t'(0)},
            '{res_t'(1), res_t'(0), 1'b1, res_t'(1)},
            '{MAXV, MAXV, 1'b1, res_t'(1)},
            '{res_t'(0), MAXV, 1'b1, res_t'(0)}
        };
        foreach (rows[i])
        begin
            want = extend_coeff(rows[i].ra, rows[i].rb);
            if (rows[i].known && want.r0 != rows[i].k0)
            begin
                mismatches++;
                $display("table row %0d disagrees with predictor", i);
            end
            send_coeff(rows[i].ra, rows[i].rb);
        end
        coeff.valid <= 1'b0;
        drain();

        // Small primes 7 and 11: inverse of 7 mod 11 is 8; covers centering both ways.
        write_reg(REG_LOW_A, 7);
        write_reg(REG_LOW_B, 11);
        write_reg(REG_INV, 8);
        write_reg(REG_TOP_0, 5);
        write_reg(REG_TOP_1, 13);
        write_reg(REG_TOP_2, 0);
        write_reg(REG_TOP_3, MAXV);
        write_reg(REG_UNUSED, 123);
        rows = '{
            '{res_t'(0), res_t'(0), 1'b0, res_t'(0)},
            '{res_t'(6), res_t'(10), 1'b0, res_t'(0)},
            '{res_t'(3), res_t'(5), 1'b0, res_t'(0)},
            '{res_t'(4), res_t'(6), 1'b0, res_t'(0)},
            '{MAXV, MAXV, 1'b0, res_t'(0)},
            '{res_t'(100), res_t'(200), 1'b0, res_t'(0)}
        };
        foreach (rows[i]) send_coeff(rows[i].ra, rows[i].rb);
        send_random(300, 1'b0);
        drain();

        // Large moduli near the top of the range, unreduced inverse.
        p = MAXV - 92;
        write_reg(REG_LOW_A, p);
        write_reg(REG_LOW_B, MAXV - 172);
        write_reg(REG_INV, MAXV);
        write_reg(REG_TOP_0, MAXV);
        write_reg(REG_TOP_1, 2);
        write_reg(REG_TOP_2, rand_res() | 1);
        write_reg(REG_TOP_3, 3);
        send_coeff(p - 1, 0);
        send_coeff(0, MAXV - 173);
        send_coeff(MAXV, MAXV);
        send_random(600, 1'b0);
        drain();

        // Random moduli with wrong inverses, then a zero low modulus.
        write_reg(REG_LOW_A, rand_res() | 2);
        write_reg(REG_LOW_B, res_t'($urandom_range(2, 1000000)));
        write_reg(REG_INV, rand_res());
        write_reg(REG_TOP_0, rand_res());
        write_reg(REG_TOP_1, res_t'($urandom_range(2, 1000)));
        write_reg(REG_TOP_2, rand_res());
        write_reg(REG_TOP_3, 1);
        send_random(700, 1'b1);
        drain();

        write_reg(REG_LOW_A, 0);
        send_coeff(MAXV, 1);
        coeff.valid <= 1'b0;
        drain();
        write_reg(REG_LOW_A, 13);
        write_reg(REG_LOW_B, 0);
        send_random(20, 1'b1);
        drain();

        write_reg(REG_LOW_A, 2);
        write_reg(REG_LOW_B, MAXV - 2);
        write_reg(REG_INV, rand_res());
        send_random(380, 1'b1);
        drain();

        if (mismatches == 0 && pending_words.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/rcbe_pkg.sv
hw/rtl/rcbe_in_if.sv
hw/rtl/rcbe_out_if.sv
hw/rtl/rcbe_mod_pipe.sv
hw/rtl/rcbe_mulmod.sv
hw/rtl/rns_centered_base_extension_top.sv
sim/tb_rcbe_channels.sv
sim/tb_rns_centered_base_extension_top.sv
